### rtl/core/mrq_pkg.sv
package mrq_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int ENTRY_BYTES_DEF = 64;
  localparam int CMD_DEPTH       = 2;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_TOO_LONG  = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_BAD_SIZE  = 3'd4;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       bad_size;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    status_t    status;
    logic [6:0] message_length;
    logic [4:0] entry_count;
    logic       queue_empty;
  } res_t;

endpackage

### rtl/core/mrq_front.sv
module mrq_front
  import mrq_pkg::*;
#(
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] request_size,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int FW = $clog2(CMD_DEPTH + 1);

  cmd_t          queue [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;
  cmd_t          incoming;

  assign in_ready  = fill != FW'(CMD_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    incoming.func      = func;
    incoming.data_byte = data_byte;
    incoming.last_byte = last_byte;
    incoming.bad_size  = request_size > 8'(ENTRY_BYTES);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/core/mrq_back.sv
module mrq_back
  import mrq_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int GW = $clog2(ENTRY_BYTES + 2);
  localparam int LW = $clog2(ENTRY_BYTES + 1);
  localparam int AW = $clog2(ENTRIES * ENTRY_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  logic [7:0]    store   [ENTRIES * ENTRY_BYTES];
  logic [LW-1:0] lengths [ENTRIES];

  state_t        state, state_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [GW-1:0] gathered, gathered_next;
  logic          lost, lost_next;
  logic [SW-1:0] rd_slot, rd_slot_next;
  logic [LW-1:0] issued, issued_next;
  logic          rd_pend, rd_pend_next;
  logic          rd_last, rd_last_next;
  logic [7:0]    rd_data;
  logic [LW-1:0] len_q;
  res_t          res_next;
  logic          res_load;

  logic          out_free;
  logic          full;
  logic          lost_now;
  logic [GW-1:0] enq_len;
  logic [LW-1:0] len_eff;
  logic          mem_we, mem_rd, len_we, len_rd;
  logic [AW-1:0] wr_addr, rd_addr;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(ENTRIES - 1)) ? '0 : s + SW'(1);
  endfunction

  assign out_free = !res_valid || res_ready;
  assign full     = count == CW'(ENTRIES);
  assign lost_now = (gathered < GW'(ENTRY_BYTES)) && full;
  assign enq_len  = (gathered <= GW'(ENTRY_BYTES)) ? gathered + GW'(1) : gathered;
  assign len_eff  = (len_q == '0) ? LW'(1) : len_q;
  assign wr_addr  = AW'(tail) * AW'(ENTRY_BYTES) + AW'(gathered);
  assign rd_addr  = AW'(rd_slot) * AW'(ENTRY_BYTES) + AW'(issued);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    gathered_next = gathered;
    lost_next     = lost;
    rd_slot_next  = rd_slot;
    issued_next   = issued;
    rd_pend_next  = rd_pend;
    rd_last_next  = rd_last;
    cmd_ready     = 1'b0;
    res_load      = 1'b0;
    res_next      = res;
    mem_we        = 1'b0;
    mem_rd        = 1'b0;
    len_we        = 1'b0;
    len_rd        = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          res_next.out_byte       = 8'd0;
          res_next.last_out       = 1'b1;
          res_next.message_length = 7'd0;
          if (cmd.func == FUNC_ENQ) begin
            mem_we = (gathered < GW'(ENTRY_BYTES)) && !full;
            if (cmd.last_byte) begin
              res_load      = 1'b1;
              gathered_next = '0;
              lost_next     = 1'b0;
              if (enq_len > GW'(ENTRY_BYTES)) begin
                res_next.status = ST_TOO_LONG;
              end else if (full || lost || lost_now) begin
                res_next.status = ST_OVERFLOW;
              end else begin
                len_we                  = 1'b1;
                tail_next               = next_slot(tail);
                count_next              = count + CW'(1);
                res_next.status         = ST_OK;
                res_next.message_length = 7'(enq_len);
              end
            end else begin
              gathered_next = enq_len;
              lost_next     = lost || lost_now;
            end
          end else if (cmd.bad_size) begin
            res_load        = 1'b1;
            res_next.status = ST_BAD_SIZE;
          end else if (count == '0) begin
            res_load        = 1'b1;
            res_next.status = ST_UNDERFLOW;
          end else begin
            len_rd       = 1'b1;
            rd_slot_next = head;
            head_next    = next_slot(head);
            count_next   = count - CW'(1);
            issued_next  = '0;
            rd_pend_next = 1'b0;
            state_next   = ST_STREAM;
          end
          res_next.entry_count = 5'(count_next);
          res_next.queue_empty = count_next == '0;
        end
      end
      ST_STREAM: begin
        if (!rd_pend || out_free) begin
          if (issued < len_eff) begin
            mem_rd       = 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = issued == len_eff - LW'(1);
            issued_next  = issued + LW'(1);
          end else begin
            rd_pend_next = 1'b0;
          end
        end
        if (rd_pend && out_free) begin
          res_load                = 1'b1;
          res_next.out_byte       = rd_data;
          res_next.last_out       = rd_last;
          res_next.status         = ST_OK;
          res_next.message_length = 7'(len_eff);
          res_next.entry_count    = 5'(count);
          res_next.queue_empty    = count == '0;
          if (rd_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= cmd.data_byte;
    end
    if (mem_rd) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      lengths[tail] <= LW'(enq_len);
    end
    if (len_rd) begin
      len_q <= lengths[head];
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_slot_next;
    rd_last <= rd_last_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      gathered  <= '0;
      lost      <= 1'b0;
      issued    <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      gathered  <= gathered_next;
      lost      <= lost_next;
      issued    <= issued_next;
      rd_pend   <= rd_pend_next;
      res_valid <= res_load || (res_valid && !res_ready);
    end
  end

endmodule

### rtl/core/message_ring_queue.sv
// Flow: an enqueue byte is taken into a two-beat command queue; the status beat on its
// last byte is loaded into the registered result output when the execution side accepts it.
// A dequeue presents its first byte after the registered length read, the byte read of the
// message store and the result register, then one byte per cycle while m_tready stays high.
// Rate: one enqueue beat per cycle while the execution side is idle and its output is not
// stalled; a dequeue holds the execution side until its last byte reaches the result register.
// Reset: synchronous rst clears pointers, counts and queues; the stores are not cleared.
module message_ring_queue
  import mrq_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // data_byte[7:0], request_size[15:8]
  input  logic                s_tuser,  // func
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // out_byte[7:0], message_length[14:8],
                                        // entry_count[19:15], queue_empty[20], zero[23:21]
  output logic [2:0]          m_tuser,  // status
  output logic                m_tlast
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  mrq_front #(
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .data_byte   (s_tdata[7:0]),
    .last_byte   (s_tlast),
    .request_size(s_tdata[15:8]),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  mrq_back #(
    .ENTRIES    (ENTRIES),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {3'd0, res.queue_empty, res.entry_count, res.message_length, res.out_byte};
  assign m_tuser = res.status;
  assign m_tlast = res.last_out;

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_BAD_SIZE))
    else $error("status code out of range");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata[7:0] == 8'd0
                                        && m_tdata[14:8] == 7'd0))
    else $error("error beat not a single zero beat");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[14:8] != 7'd0))
    else $error("ok beat with zero length");

endmodule
